// ===== rtl/core/alr_pkg.sv =====
// alr_pkg: shared constants, types and state encodings for alpha_layer_repeat.
// Used by the divider, the top level and the interfaces' users; no dependencies.
`timescale 1ns / 1ps

package alr_pkg;

  // Fixed-point format and repeat bound
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned MAX_REPEAT = 64;

  // Field widths
  localparam int unsigned CH_W  = 16;                          // colour channel
  localparam int unsigned CNT_W = 8;                           // repeat count
  localparam int unsigned REP_W = $clog2(MAX_REPEAT + 1);      // layer counter
  localparam int unsigned NCH   = 4;                           // r, g, b, a

  // Datapath widths
  localparam int unsigned OP_W   = 18;                         // multiplier operand
  localparam int unsigned PROD_W = 2 * OP_W;                   // raw product
  localparam int unsigned NUM_W  = 34;                         // signed dividend
  localparam int unsigned MAG_W  = NUM_W - 1;                  // dividend magnitude
  localparam int unsigned DMAG_W = OP_W - 1;                   // divisor magnitude
  localparam int unsigned Q_W    = 16;                         // quotient bits
  localparam int unsigned QCNT_W = $clog2(Q_W);

  // 1.0 in channel and operand widths
  localparam logic [CH_W-1:0]        ONE_CH = CH_W'(1 << FRAC_BITS);
  localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(1 << FRAC_BITS);

  // Channel indexes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_HEAD,
    ST_SETUP,
    ST_COLOUR,
    ST_MUL,
    ST_NUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ALPHA,
    ST_NEXT,
    ST_OUT
  } alr_state_e;

  // Divider states
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHK,
    DIV_RUN,
    DIV_DONE
  } alr_div_state_e;

  // Divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [OP_W-1:0]  den;
  } alr_div_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] value;
    logic            clamp;
  } alr_div_rsp_t;

endpackage

// ===== rtl/core/alr_if.sv =====
// alr_if: valid/ready channel interfaces for alpha_layer_repeat input and result words.
// Depends on nothing; widths follow the field definitions of the block.
`timescale 1ns / 1ps

interface alr_in_if;
  logic              valid;
  logic              ready;
  logic [15:0]       base_red;
  logic [15:0]       base_green;
  logic [15:0]       base_blue;
  logic [15:0]       base_alpha;
  logic [15:0]       over_red;
  logic [15:0]       over_green;
  logic [15:0]       over_blue;
  logic [15:0]       over_alpha;
  logic signed [7:0] repeat_count;

  modport source (
    output valid, base_red, base_green, base_blue, base_alpha,
    output over_red, over_green, over_blue, over_alpha, repeat_count,
    input  ready
  );
  modport sink (
    input  valid, base_red, base_green, base_blue, base_alpha,
    input  over_red, over_green, over_blue, over_alpha, repeat_count,
    output ready
  );
endinterface

interface alr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;
  logic        clamped_flag;
  logic        divide_error;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha, clamped_flag, divide_error,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha, clamped_flag, divide_error,
    output ready
  );
endinterface

// ===== rtl/core/alpha_layer_repeat.sv =====
// alpha_layer_repeat: repeated straight-alpha "over" compositing and its inverse, Q1.15.
// Depends on alr_pkg, alr_in_if / alr_out_if and the shared divider alr_div.
//
//   channel | dir | word                                   | handshake
//   --------+-----+----------------------------------------+-----------
//   in_i    | in  | base rgba, overlay rgba, repeat_count  | valid/ready
//   out_o   | out | out rgba, clamped_flag, divide_error   | valid/ready
//
// One word at a time: accept, form the overlay products oc * oa per colour, then run
// each layer in turn; the result then waits in the output until taken. Each colour
// (and, on removal, alpha) takes one pass of the radix-2 divider unless its divisor is
// degenerate. At most 64 layers are applied; a zero count skips straight to the output.
// Reset is asynchronous, active low; it returns the sequencer and divider to idle.
// in_i.ready is low from acceptance until the result word has been taken.
`timescale 1ns / 1ps

module alpha_layer_repeat import alr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  alr_in_if.sink    in_i,
  alr_out_if.source out_o
);

  alr_state_e              state_q, state_d;
  logic [1:0]              ch_q, ch_d;
  logic [REP_W-1:0]        n_q, n_d;
  logic                    add_q, add_d;
  logic                    clamped_q, clamped_d;
  logic                    err_q, err_d;

  logic [CH_W-1:0]         c_q [NCH];
  logic [CH_W-1:0]         c_d [NCH];
  logic [CH_W-1:0]         oc_q [3];
  logic [CH_W-1:0]         oc_d [3];
  logic [CH_W-1:0]         oa_q, oa_d;
  logic signed [NUM_W-1:0] po_q [3];
  logic signed [NUM_W-1:0] po_d [3];
  logic signed [NUM_W-1:0] p_q, p_d;
  logic signed [NUM_W-1:0] num_q, num_d;
  logic signed [OP_W-1:0]  t_q, t_d;
  logic signed [OP_W-1:0]  s_q, s_d;

  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [OP_W-1:0]   d_val;
  logic signed [NUM_W-1:0]  p_adj;
  logic signed [NUM_W-1:0]  t_full;
  logic signed [OP_W-1:0]   t_comb;
  logic [CH_W-1:0]          c_sel;
  logic [CH_W-1:0]          oc_sel;
  logic signed [NUM_W-1:0]  po_sel;
  logic [CH_W-1:0]          base_in [NCH];
  logic [CNT_W-1:0]         cnt_mag;

  alr_div_req_t            div_req;
  alr_div_rsp_t            div_rsp;

  // Shared divider
  alr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared multiplier
  assign prod  = mul_a * mul_b;
  assign d_val = ONE_OP - OP_W'(oa_q);

  // t = a * (1 - oa) / 1.0, truncated toward zero
  assign p_adj  = p_q + (p_q[NUM_W-1] ? NUM_W'(ONE_CH - 1'b1) : NUM_W'(0));
  assign t_full = p_adj >>> FRAC_BITS;
  assign t_comb = t_full[OP_W-1:0];

  // Per-channel operand selection
  assign c_sel = c_q[ch_q];
  always_comb begin
    case (ch_q)
      CH_RED:   begin oc_sel = oc_q[0]; po_sel = po_q[0]; end
      CH_GREEN: begin oc_sel = oc_q[1]; po_sel = po_q[1]; end
      CH_BLUE:  begin oc_sel = oc_q[2]; po_sel = po_q[2]; end
      default:  begin oc_sel = '0;      po_sel = '0;      end
    endcase
  end

  // Input fields and count magnitude
  assign base_in[0] = in_i.base_red;
  assign base_in[1] = in_i.base_green;
  assign base_in[2] = in_i.base_blue;
  assign base_in[3] = in_i.base_alpha;
  assign cnt_mag    = in_i.repeat_count[CNT_W-1] ? CNT_W'(-in_i.repeat_count)
                                                 : CNT_W'(in_i.repeat_count);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ch_q      <= CH_RED;
      n_q       <= '0;
      add_q     <= 1'b0;
      clamped_q <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      n_q       <= n_d;
      add_q     <= add_d;
      clamped_q <= clamped_d;
      err_q     <= err_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    oc_q  <= oc_d;
    oa_q  <= oa_d;
    po_q  <= po_d;
    p_q   <= p_d;
    num_q <= num_d;
    t_q   <= t_d;
    s_q   <= s_d;
  end

  // Sequencer: next state, multiplier operands, divider requests
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    n_d       = n_q;
    add_d     = add_q;
    clamped_d = clamped_q;
    err_d     = err_q;
    c_d       = c_q;
    oc_d      = oc_q;
    oa_d      = oa_q;
    po_d      = po_q;
    p_d       = p_q;
    num_d     = num_q;
    t_d       = t_q;
    s_d       = s_q;
    mul_a     = '0;
    mul_b     = '0;
    div_req.start = 1'b0;
    div_req.num   = num_q;
    div_req.den   = (ch_q == CH_ALPHA) ? d_val : s_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          clamped_d = 1'b0;
          err_d     = 1'b0;
          for (int i = 0; i < NCH; i++) begin
            if (base_in[i] > ONE_CH) begin
              c_d[i]    = ONE_CH;
              clamped_d = 1'b1;
            end else begin
              c_d[i] = base_in[i];
            end
          end
          oc_d[0] = in_i.over_red;
          oc_d[1] = in_i.over_green;
          oc_d[2] = in_i.over_blue;
          oa_d    = in_i.over_alpha;
          add_d   = !in_i.repeat_count[CNT_W-1];
          n_d     = (32'(cnt_mag) > MAX_REPEAT) ? REP_W'(MAX_REPEAT) : REP_W'(cnt_mag);
          ch_d    = CH_RED;
          state_d = ST_PRE;
        end
      end

      // oc * oa for each colour, fixed for the whole word
      ST_PRE: begin
        mul_a = OP_W'(oc_sel);
        mul_b = OP_W'(oa_q);
        case (ch_q)
          CH_RED:   po_d[0] = prod[NUM_W-1:0];
          CH_GREEN: po_d[1] = prod[NUM_W-1:0];
          CH_BLUE:  po_d[2] = prod[NUM_W-1:0];
          default:  ;
        endcase
        if (ch_q == CH_BLUE) begin
          ch_d    = CH_RED;
          state_d = (n_q == '0) ? ST_OUT : ST_HEAD;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end

      // Add: a * (1 - oa); remove: s = a - oa
      ST_HEAD: begin
        if (add_q) begin
          mul_a   = OP_W'(c_q[CH_ALPHA]);
          mul_b   = d_val;
          p_d     = prod[NUM_W-1:0];
          state_d = ST_SETUP;
        end else begin
          s_d     = OP_W'(c_q[CH_ALPHA]) - OP_W'(oa_q);
          state_d = ST_COLOUR;
        end
      end

      ST_SETUP: begin
        t_d     = t_comb;
        s_d     = t_comb + OP_W'(oa_q);
        state_d = ST_COLOUR;
      end

      // Degenerate divisors
      ST_COLOUR: begin
        if (add_q) begin
          if (s_q[OP_W-1] || s_q == '0) begin
            c_d[0]  = '0;
            c_d[1]  = '0;
            c_d[2]  = '0;
            state_d = ST_ALPHA;
          end else begin
            state_d = ST_MUL;
          end
        end else if (s_q == '0 || d_val == '0) begin
          for (int i = 0; i < NCH; i++) begin
            c_d[i] = '0;
          end
          err_d   = 1'b1;
          state_d = ST_NEXT;
        end else begin
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        mul_a   = OP_W'(c_sel);
        mul_b   = add_q ? t_q : OP_W'(c_q[CH_ALPHA]);
        p_d     = prod[NUM_W-1:0];
        state_d = ST_NUM;
      end

      ST_NUM: begin
        num_d   = add_q ? p_q + po_sel : p_q - po_sel;
        state_d = ST_DIV_GO;
      end

      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          c_d[ch_q] = div_rsp.value;
          clamped_d = clamped_q | div_rsp.clamp;
          if (ch_q == CH_ALPHA) begin
            state_d = ST_NEXT;
          end else if (ch_q == CH_BLUE) begin
            state_d = ST_ALPHA;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_MUL;
          end
        end
      end

      // Add: alpha is s, clamped; remove: s * 1.0 / (1 - oa)
      ST_ALPHA: begin
        if (add_q) begin
          if (s_q[OP_W-1]) begin
            c_d[CH_ALPHA] = '0;
            clamped_d     = 1'b1;
          end else if (s_q > ONE_OP) begin
            c_d[CH_ALPHA] = ONE_CH;
            clamped_d     = 1'b1;
          end else begin
            c_d[CH_ALPHA] = s_q[CH_W-1:0];
          end
          state_d = ST_NEXT;
        end else begin
          num_d   = NUM_W'(s_q) <<< FRAC_BITS;
          ch_d    = CH_ALPHA;
          state_d = ST_DIV_GO;
        end
      end

      ST_NEXT: begin
        n_d     = n_q - 1'b1;
        ch_d    = CH_RED;
        state_d = (n_q == REP_W'(1)) ? ST_OUT : ST_HEAD;
      end

      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Ports
  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = (state_q == ST_OUT);
  assign out_o.out_red      = c_q[0];
  assign out_o.out_green    = c_q[1];
  assign out_o.out_blue     = c_q[2];
  assign out_o.out_alpha    = c_q[3];
  assign out_o.clamped_flag = clamped_q;
  assign out_o.divide_error = err_q;

endmodule

// ===== rtl/core/alr_div.sv =====
// alr_div: radix-2 signed divider with saturation to the unit range [0, 1.0].
// Depends on alr_pkg. One quotient bit per cycle, 16 bits plus an overflow check.
`timescale 1ns / 1ps

module alr_div import alr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  alr_div_req_t req_i,
  output alr_div_rsp_t rsp_o
);

  alr_div_state_e    state_q, state_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [DMAG_W-1:0] dmag_q, dmag_d;
  logic              neg_q, neg_d;
  logic [MAG_W-1:0]  rem_q, rem_d;
  logic [MAG_W-2:0]  dsh_q, dsh_d;
  logic [Q_W-1:0]    quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [QCNT_W-1:0] bit_q, bit_d;

  logic [NUM_W-1:0]  num_abs;
  logic [OP_W-1:0]   den_abs;
  logic              ge;

  // Magnitudes of the operands
  assign num_abs = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : req_i.num;
  assign den_abs = req_i.den[OP_W-1]  ? OP_W'(-req_i.den)  : req_i.den;
  assign ge      = rem_q >= {1'b0, dsh_q};

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
  end

  // Sequencing and one restoring step per cycle
  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    mag_d   = mag_q;
    dmag_d  = dmag_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          mag_d   = num_abs[MAG_W-1:0];
          dmag_d  = den_abs[DMAG_W-1:0];
          neg_d   = req_i.num[NUM_W-1] ^ req_i.den[OP_W-1];
          state_d = DIV_CHK;
        end
      end
      DIV_CHK: begin
        // quotient of 2^16 or more saturates without iterating
        ovf_d   = mag_q >= {dmag_q, {Q_W{1'b0}}};
        rem_d   = mag_q;
        dsh_d   = {dmag_q, {(Q_W-1){1'b0}}};
        quo_d   = '0;
        bit_d   = '0;
        state_d = (mag_q >= {dmag_q, {Q_W{1'b0}}}) ? DIV_DONE : DIV_RUN;
      end
      DIV_RUN: begin
        rem_d = ge ? rem_q - {1'b0, dsh_q} : rem_q;
        quo_d = {quo_q[Q_W-2:0], ge};
        dsh_d = dsh_q >> 1;
        bit_d = bit_q + 1'b1;
        if (bit_q == QCNT_W'(Q_W - 1)) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        state_d = DIV_IDLE;
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  // Sign and unit-range clamp of the result
  always_comb begin
    rsp_o.done  = (state_q == DIV_DONE);
    rsp_o.value = '0;
    rsp_o.clamp = 1'b0;
    if (ovf_q) begin
      rsp_o.value = neg_q ? '0 : ONE_CH;
      rsp_o.clamp = 1'b1;
    end else if (quo_q == '0) begin
      rsp_o.value = '0;
    end else if (neg_q) begin
      rsp_o.clamp = 1'b1;
    end else if (quo_q > ONE_CH) begin
      rsp_o.value = ONE_CH;
      rsp_o.clamp = 1'b1;
    end else begin
      rsp_o.value = quo_q;
    end
  end

endmodule

// ===== rtl/core/alr_checker.sv =====
// alr_checker: port-level assertions for alpha_layer_repeat, bound to the top level.
// Depends on nothing but the top level's channel signals.
`timescale 1ns / 1ps

module alr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_red_i,
  input logic [15:0] out_green_i,
  input logic [15:0] out_blue_i,
  input logic [15:0] out_alpha_i,
  input logic        clamped_flag_i,
  input logic        divide_error_i
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // A stalled result word stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A stalled result word does not change
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_red_i, out_green_i, out_blue_i,
                                             out_alpha_i, clamped_flag_i,
                                             divide_error_i}))
    else $error("result word changed while stalled");

  // One word in flight: no new input while a result is offered
  a_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a result is pending");

  // Accepting a word starts work; no result in the next cycle
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i && !out_valid_i)
    else $error("block not busy after accepting a word");

  // Handing over the result returns the block to idle
  a_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> in_ready_i && !out_valid_i)
    else $error("block not idle after the result was taken");

endmodule

bind alpha_layer_repeat alr_checker u_alr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_red_i      (out_o.out_red),
  .out_green_i    (out_o.out_green),
  .out_blue_i     (out_o.out_blue),
  .out_alpha_i    (out_o.out_alpha),
  .clamped_flag_i (out_o.clamped_flag),
  .divide_error_i (out_o.divide_error)
);

// ===== tb/alpha_layer_repeat_tb.sv =====
// alpha_layer_repeat_tb: self-checking bench for the repeated straight-alpha over block.
// Depends on alr_pkg, the alr_in_if / alr_out_if interfaces and the alpha_layer_repeat RTL.
// A scoreboard class predicts each result; tasks drive input, a process stalls output.
`timescale 1ns / 1ps

module alpha_layer_repeat_tb;
  import alr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 40000;  // well above the longest word
  localparam int unsigned DRAIN_CYCLES   = 6000;
  localparam int unsigned RANDOM_WORDS   = 160;

  // One input word and one result word, at the block's widths
  typedef struct packed {
    logic [CH_W-1:0]         base_red;
    logic [CH_W-1:0]         base_green;
    logic [CH_W-1:0]         base_blue;
    logic [CH_W-1:0]         base_alpha;
    logic [CH_W-1:0]         over_red;
    logic [CH_W-1:0]         over_green;
    logic [CH_W-1:0]         over_blue;
    logic [CH_W-1:0]         over_alpha;
    logic signed [CNT_W-1:0] repeat_count;
  } layer_word_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
    logic            clamped_flag;
    logic            divide_error;
  } pixel_t;

  // Predicts composited pixels and matches them against result words in order
  class blend_scoreboard;
    pixel_t      expected_px[$];
    int unsigned errors;

    function longint fit_unit(longint v, inout bit hit);
      longint one;
      one = longint'(1) << FRAC_BITS;
      if (v < 0) begin
        hit = 1'b1;
        return 0;
      end
      if (v > one) begin
        hit = 1'b1;
        return one;
      end
      return v;
    endfunction

    function pixel_t over_composite(layer_word_t w);
      longint c[4];
      longint o[4];
      longint one, cnt, n, s, t, d;
      bit     hit, err;
      pixel_t px;
      one  = longint'(1) << FRAC_BITS;
      hit  = 1'b0;
      err  = 1'b0;
      c[0] = fit_unit(longint'(w.base_red), hit);
      c[1] = fit_unit(longint'(w.base_green), hit);
      c[2] = fit_unit(longint'(w.base_blue), hit);
      c[3] = fit_unit(longint'(w.base_alpha), hit);
      o[0] = longint'(w.over_red);
      o[1] = longint'(w.over_green);
      o[2] = longint'(w.over_blue);
      o[3] = longint'(w.over_alpha);
      cnt  = longint'($signed(w.repeat_count));
      if (cnt > longint'(MAX_REPEAT)) cnt = longint'(MAX_REPEAT);
      if (cnt < -longint'(MAX_REPEAT)) cnt = -longint'(MAX_REPEAT);
      n = (cnt < 0) ? -cnt : cnt;
      for (longint k = 0; k < n; k++) begin
        if (cnt > 0) begin
          // lay one more overlay on top
          t = (c[3] * (one - o[3])) / one;
          s = t + o[3];
          for (int i = 0; i < 3; i++)
            c[i] = (s > 0) ? (c[i] * t + o[i] * o[3]) / s : 0;
          c[3] = s;
        end else begin
          // peel one overlay off; a zero divisor blanks the whole colour
          s = c[3] - o[3];
          d = one - o[3];
          if (s == 0 || d == 0) begin
            err = 1'b1;
            for (int i = 0; i < 4; i++) c[i] = 0;
          end else begin
            for (int i = 0; i < 3; i++)
              c[i] = (c[i] * c[3] - o[i] * o[3]) / s;
            c[3] = (s * one) / d;
          end
        end
        for (int i = 0; i < 4; i++) c[i] = fit_unit(c[i], hit);
      end
      px.out_red      = CH_W'(c[0]);
      px.out_green    = CH_W'(c[1]);
      px.out_blue     = CH_W'(c[2]);
      px.out_alpha    = CH_W'(c[3]);
      px.clamped_flag = hit;
      px.divide_error = err;
      return px;
    endfunction

    function void note_word(layer_word_t w);
      expected_px.push_back(over_composite(w));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t sb: %s", $time, msg);
    endtask

    task cmp_field(string name, longint got, longint want);
      if (got != want)
        report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(pixel_t got);
      pixel_t want;
      if (expected_px.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = expected_px.pop_front();
        cmp_field("out_red", got.out_red, want.out_red);
        cmp_field("out_green", got.out_green, want.out_green);
        cmp_field("out_blue", got.out_blue, want.out_blue);
        cmp_field("out_alpha", got.out_alpha, want.out_alpha);
        cmp_field("clamped_flag", got.clamped_flag, want.clamped_flag);
        cmp_field("divide_error", got.divide_error, want.divide_error);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  alr_in_if  in_if ();
  alr_out_if out_if ();

  alpha_layer_repeat DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  blend_scoreboard sb = new;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Result side: take words, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready)
      sb.check_result({out_if.out_red, out_if.out_green, out_if.out_blue,
                       out_if.out_alpha, out_if.clamped_flag, out_if.divide_error});
    out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic layer_word_t mk_word(int br, int bg, int bb, int ba,
                                          int orr, int og, int ob, int oa, int cnt);
    layer_word_t w;
    w.base_red     = CH_W'(br);
    w.base_green   = CH_W'(bg);
    w.base_blue    = CH_W'(bb);
    w.base_alpha   = CH_W'(ba);
    w.over_red     = CH_W'(orr);
    w.over_green   = CH_W'(og);
    w.over_blue    = CH_W'(ob);
    w.over_alpha   = CH_W'(oa);
    w.repeat_count = CNT_W'(cnt);
    return w;
  endfunction

  // Mostly in-range fractions, with the ends and raw 16-bit values mixed in
  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ONE_CH;
      2:       return CH_W'($urandom);
      default: return CH_W'($urandom_range(0, 32768));
    endcase
  endfunction

  // Short counts dominate; full-byte and bound values now and then
  function automatic logic signed [CNT_W-1:0] rand_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return CNT_W'($urandom);
    if (r < 15) return $urandom_range(0, 1) ? CNT_W'(64) : CNT_W'(-64);
    return CNT_W'(int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic layer_word_t rand_word();
    layer_word_t w;
    w = {rand_chan(), rand_chan(), rand_chan(), rand_chan(),
         rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_count()};
    // removals mostly get an alpha that can actually be peeled
    if (w.repeat_count < 0 && $urandom_range(0, 9) < 7) begin
      w.base_alpha = CH_W'($urandom_range(1, 32768));
      w.over_alpha = CH_W'($urandom_range(0, w.base_alpha));
    end
    return w;
  endfunction

  // Offer one word, with random gaps ahead of it, and note it once taken
  task drive_word(layer_word_t w);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.base_red     <= w.base_red;
    in_if.base_green   <= w.base_green;
    in_if.base_blue    <= w.base_blue;
    in_if.base_alpha   <= w.base_alpha;
    in_if.over_red     <= w.over_red;
    in_if.over_green   <= w.over_green;
    in_if.over_blue    <= w.over_blue;
    in_if.over_alpha   <= w.over_alpha;
    in_if.repeat_count <= w.repeat_count;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_word(w);
  endtask

  // Hold the sender off until every predicted pixel has come back
  task wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_px.size() != 0);
  endtask

  initial begin
    layer_word_t directed[$];
    layer_word_t w;
    layer_word_t peel;
    pixel_t      mid;
    int unsigned sent;
    int          k;

    quiet_cycles       = 0;
    tx_gap_pct         = 0;
    rx_stall_pct       = 0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.base_red     <= '0;
    in_if.base_green   <= '0;
    in_if.base_blue    <= '0;
    in_if.base_alpha   <= '0;
    in_if.over_red     <= '0;
    in_if.over_green   <= '0;
    in_if.over_blue    <= '0;
    in_if.over_alpha   <= '0;
    in_if.repeat_count <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero count, single steps, bounds, clamps and zero divisors
    directed.push_back(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_word(32768, 32768, 32768, 32768, 12000, 5, 700, 9000, 0));
    directed.push_back(mk_word(65535, 40000, 32769, 65535, 1, 2, 3, 4, 0));
    directed.push_back(mk_word(1000, 2000, 3000, 16384, 30000, 100, 5000, 8192, 1));
    directed.push_back(mk_word(20000, 10000, 5000, 30000, 1000, 2000, 3000, 8192, -1));
    directed.push_back(mk_word(4000, 8000, 12000, 6000, 25000, 15000, 500, 3000, 64));
    directed.push_back(mk_word(30000, 20000, 10000, 32768, 2000, 100, 9000, 1200, -64));
    directed.push_back(mk_word(100, 200, 300, 400, 32768, 16384, 0, 20000, 127));
    directed.push_back(mk_word(16000, 16000, 16000, 32000, 500, 500, 500, 700, -128));
    directed.push_back(mk_word(10000, 20000, 30000, 32768, 100, 200, 300, 32768, -2));
    directed.push_back(mk_word(10000, 20000, 30000, 12345, 100, 200, 300, 12345, -3));
    directed.push_back(mk_word(9000, 8000, 7000, 0, 6000, 5000, 4000, 0, 3));
    directed.push_back(mk_word(9000, 8000, 7000, 20000, 6000, 5000, 4000, 65535, 2));
    directed.push_back(mk_word(0, 0, 0, 0, 65535, 65535, 65535, 32768, 1));
    directed.push_back(mk_word(20000, 20000, 20000, 30000, 65535, 65535, 65535, 1000, -2));
    directed.push_back(mk_word(1, 2, 3, 5, 20000, 10000, 5000, 32768, 1));
    directed.push_back(mk_word(5000, 5000, 5000, 0, 3000, 3000, 3000, 2000, -1));
    directed.push_back(mk_word(5000, 5000, 5000, 0, 3000, 3000, 3000, 0, 1));
    directed.push_back(mk_word(50000, 100, 33000, 20000, 8000, 9000, 1000, 10000, 5));
    directed.push_back(mk_word(32768, 0, 32768, 32768, 0, 32768, 0, 40000, -4));
    foreach (directed[i]) drive_word(directed[i]);

    // Random: three idling regimes, drained in between
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      tx_gap_pct   = (ph == 0) ? 38 : (ph == 1) ? 49 : 0;
      rx_stall_pct = (ph == 0) ? 49 : (ph == 1) ? 38 : 0;
      sent = 0;
      while (sent < RANDOM_WORDS / 3) begin
        if ($urandom_range(0, 99) < 25) begin
          // lay k layers, then peel the same k off the result
          k = $urandom_range(1, 6);
          w = rand_word();
          w.repeat_count = CNT_W'(k);
          mid  = sb.over_composite(w);
          peel = w;
          peel.base_red     = mid.out_red;
          peel.base_green   = mid.out_green;
          peel.base_blue    = mid.out_blue;
          peel.base_alpha   = mid.out_alpha;
          peel.repeat_count = CNT_W'(-k);
          drive_word(w);
          drive_word(peel);
          sent += 2;
        end else begin
          drive_word(rand_word());
          sent += 1;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_px.size() != 0)
      sb.report($sformatf("%0d expected pixels never came", sb.expected_px.size()));
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
